### hdl/triangulated_grid_height_interp_assert.svh
// Assertion macros for the triangulated grid height interpolator.
// Used by the top level; no other dependencies.
`ifndef TRIANGULATED_GRID_HEIGHT_INTERP_ASSERT_SVH
`define TRIANGULATED_GRID_HEIGHT_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
`define TGHI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TGHI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TGHI_ASSERT(lbl, prop, msg)
`define TGHI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/tghi_pkg.sv
// Shared constants and types of the triangulated grid height interpolator.
// No dependencies.
package tghi_pkg;

  localparam int GRID_DIM   = 64;
  localparam int CELL_W     = $clog2(GRID_DIM);
  localparam int BANK_DEPTH = GRID_DIM * GRID_DIM / 4;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int FRAC_W     = 17;
  localparam int NUM_BANKS  = 4;

  typedef enum logic [2:0] {
    REG_BASE_X      = 3'd0,
    REG_BASE_Y      = 3'd1,
    REG_BASE_Z      = 3'd2,
    REG_INV_X_SCALE = 3'd3,
    REG_INV_Y_SCALE = 3'd4,
    REG_Z_SCALE     = 3'd5,
    REG_GRID_WIDTH  = 3'd6,
    REG_GRID_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] cell_idx;
    logic [FRAC_W-1:0] frac;
  } axis_t;

endpackage

### hdl/tghi_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module tghi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tghi_axis.sv
// Maps one scaled axis coordinate to a cell index and a fraction.
// Depends on tghi_pkg.
module tghi_axis (
  input  logic [63:0]        prod_i,
  input  logic               neg_i,
  input  logic [6:0]         size_i,
  output tghi_pkg::axis_t    axis_o
);

  logic [31:0] size_raw;
  logic [31:0] eff;
  logic [31:0] cell_idx;
  logic [16:0] frac;
  logic        ok;

  always_comb begin
    size_raw = 32'(size_i);
    eff = (size_raw > 32'(tghi_pkg::GRID_DIM)) ? 32'(tghi_pkg::GRID_DIM) : size_raw;
    cell_idx = prod_i[63:32];
    frac = {1'b0, prod_i[31:16]};
    ok = (eff >= 32'd2) && !(neg_i && (prod_i != 64'd0));
    // A point exactly on the far edge belongs to the last cell at fraction one.
    if (frac == 17'd0 && cell_idx == eff - 32'd1) begin
      cell_idx = eff - 32'd2;
      frac = 17'h10000;
    end
    if (cell_idx >= eff - 32'd1) begin
      ok = 1'b0;
    end
    axis_o.ok       = ok;
    axis_o.cell_idx = cell_idx[tghi_pkg::CELL_W-1:0];
    axis_o.frac     = frac;
  end

endmodule

### hdl/triangulated_grid_height_interp.sv
// One word per cycle is sustained while the output is not stalled.
// Eight register stages; the grid is four parity banks, so all corners read at once.
// Sample writes take effect in stage 2 and give no result.
// Reset clears valid bits and sets the configuration to its defaults; the grid is undefined until written.
// Depends on tghi_pkg, tghi_ram, tghi_axis and the assertion header.
`include "triangulated_grid_height_interp_assert.svh"
module triangulated_grid_height_interp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [5:0]         sample_col_i,
  input  logic [5:0]         sample_row_i,
  input  logic signed [15:0] sample_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [39:0] elevation_o,
  output logic               in_domain_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int CW = tghi_pkg::CELL_W;
  localparam int AW = tghi_pkg::BANK_AW;

  // Configuration.
  logic signed [31:0] base_x_q, base_y_q, base_z_q;
  logic [31:0]        inv_x_q, inv_y_q;
  logic signed [23:0] z_scale_q;
  logic [6:0]         grid_w_q, grid_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q  <= '0;
      base_y_q  <= '0;
      base_z_q  <= '0;
      inv_x_q   <= 32'h0001_0000;
      inv_y_q   <= 32'h0001_0000;
      z_scale_q <= 24'h01_0000;
      grid_w_q  <= 7'(tghi_pkg::GRID_DIM);
      grid_h_q  <= 7'(tghi_pkg::GRID_DIM);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tghi_pkg::cfg_reg_e'(cfg_index_i))
        tghi_pkg::REG_BASE_X:      base_x_q  <= cfg_data_i;
        tghi_pkg::REG_BASE_Y:      base_y_q  <= cfg_data_i;
        tghi_pkg::REG_BASE_Z:      base_z_q  <= cfg_data_i;
        tghi_pkg::REG_INV_X_SCALE: inv_x_q   <= cfg_data_i;
        tghi_pkg::REG_INV_Y_SCALE: inv_y_q   <= cfg_data_i;
        tghi_pkg::REG_Z_SCALE:     z_scale_q <= cfg_data_i[23:0];
        tghi_pkg::REG_GRID_WIDTH:  grid_w_q  <= cfg_data_i[6:0];
        tghi_pkg::REG_GRID_HEIGHT: grid_h_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage load enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, ov_q;
  logic en1, en2, en3, en4, en5, en6, en7, en_out;

  assign en_out = !ov_q || !out_stall_i;
  assign en7 = !v7_q || en_out;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  logic wr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= in_valid_i;
      if (en2)    v2_q <= v1_q;
      // Sample writes finish in the RAM and leave the pipeline here.
      if (en3)    v3_q <= v2_q && !wr2_q;
      if (en4)    v4_q <= v3_q;
      if (en5)    v5_q <= v4_q;
      if (en6)    v6_q <= v5_q;
      if (en7)    v7_q <= v6_q;
      if (en_out) ov_q <= v7_q;
    end
  end

  // Stage 1: offset from the base point, split into sign and magnitude.
  logic               wr1_q, negx1_q, negy1_q;
  logic [31:0]        magx1_q, magy1_q;
  logic [CW-1:0]      col1_q, row1_q, col2_q, row2_q;
  logic signed [15:0] h1_q, h2_q;
  logic signed [32:0] dx, dy;

  assign dx = 33'(pos_x_i) - 33'(base_x_q);
  assign dy = 33'(pos_y_i) - 33'(base_y_q);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      wr1_q   <= req_type_i;
      negx1_q <= dx[32];
      negy1_q <= dy[32];
      magx1_q <= dx[32] ? 32'(-dx) : dx[31:0];
      magy1_q <= dy[32] ? 32'(-dy) : dy[31:0];
      col1_q  <= CW'(sample_col_i);
      row1_q  <= CW'(sample_row_i);
      h1_q    <= sample_height_i;
    end
  end

  // Stage 2: scale by the reciprocal cell size.
  logic        negx2_q, negy2_q;
  logic [63:0] prodx2_q, prody2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      wr2_q    <= wr1_q;
      negx2_q  <= negx1_q;
      negy2_q  <= negy1_q;
      prodx2_q <= 64'(magx1_q) * 64'(inv_x_q);
      prody2_q <= 64'(magy1_q) * 64'(inv_y_q);
      col2_q   <= col1_q;
      row2_q   <= row1_q;
      h2_q     <= h1_q;
    end
  end

  tghi_pkg::axis_t ax, ay;

  tghi_axis u_axis_x (.prod_i(prodx2_q), .neg_i(negx2_q), .size_i(grid_w_q), .axis_o(ax));
  tghi_axis u_axis_y (.prod_i(prody2_q), .neg_i(negy2_q), .size_i(grid_h_q), .axis_o(ay));

  // Grid banks by column and row parity; bank index is {row parity, column parity}.
  logic [15:0]                    rd [tghi_pkg::NUM_BANKS];
  logic [tghi_pkg::NUM_BANKS-1:0] bank_we, bank_re;

  for (genvar b = 0; b < tghi_pkg::NUM_BANKS; b++) begin : g_bank
    localparam logic ColPar = 1'(b);
    localparam logic RowPar = 1'(b / 2);
    logic [CW-1:0] colsel, rowsel;
    assign colsel = (ax.cell_idx[0] == ColPar) ? ax.cell_idx : ax.cell_idx + CW'(1);
    assign rowsel = (ay.cell_idx[0] == RowPar) ? ay.cell_idx : ay.cell_idx + CW'(1);
    assign bank_we[b] = en3 && v2_q && wr2_q && (col2_q[0] == ColPar) && (row2_q[0] == RowPar);
    assign bank_re[b] = en3 && v2_q && !wr2_q;

    tghi_ram #(.WIDTH(16), .DEPTH(tghi_pkg::BANK_DEPTH)) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we[b]),
      .waddr_i(AW'({row2_q[CW-1:1], col2_q[CW-1:1]})),
      .wdata_i(h2_q),
      .re_i   (bank_re[b]),
      .raddr_i(AW'({rowsel[CW-1:1], colsel[CW-1:1]})),
      .rdata_o(rd[b])
    );
  end

  // Stage 3: cell parity and fractions wait beside the RAM read.
  logic                        ok3_q, cx3_q, cy3_q;
  logic [tghi_pkg::FRAC_W-1:0] fx3_q, fy3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ok3_q <= ax.ok && ay.ok;
      cx3_q <= ax.cell_idx[0];
      cy3_q <= ay.cell_idx[0];
      fx3_q <= ax.frac;
      fy3_q <= ay.frac;
    end
  end

  // Stage 4: pick the triangle and form the corner differences.
  logic signed [15:0] ca, cb, cc;
  logic               upper;

  always_comb begin
    upper = fx3_q > fy3_q;
    ca = rd[{cy3_q, cx3_q}];
    cc = rd[{!cy3_q, !cx3_q}];
    cb = upper ? rd[{cy3_q, !cx3_q}] : rd[{!cy3_q, cx3_q}];
  end

  logic                        ok4_q;
  logic signed [15:0]          a4_q;
  logic signed [16:0]          db4_q, dc4_q;
  logic [tghi_pkg::FRAC_W-1:0] f1_4_q, f2_4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ok4_q  <= ok3_q;
      a4_q   <= ca;
      db4_q  <= 17'(cb) - 17'(ca);
      dc4_q  <= 17'(cc) - 17'(cb);
      f1_4_q <= upper ? fx3_q : fy3_q;
      f2_4_q <= upper ? fy3_q : fx3_q;
    end
  end

  // Stage 5: weight the differences.
  logic               ok5_q;
  logic signed [15:0] a5_q;
  logic signed [34:0] p1_5_q, p2_5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      ok5_q  <= ok4_q;
      a5_q   <= a4_q;
      p1_5_q <= $signed({1'b0, f1_4_q}) * db4_q;
      p2_5_q <= $signed({1'b0, f2_4_q}) * dc4_q;
    end
  end

  // Stage 6: interpolated sample in Q.16.
  logic               ok6_q;
  logic signed [35:0] val6_q;

  always_ff @(posedge clk_i) begin
    if (en6) begin
      ok6_q  <= ok5_q;
      val6_q <= $signed({20'(a5_q), 16'd0}) + 36'(p1_5_q) + 36'(p2_5_q);
    end
  end

  // Stage 7: height scale.
  logic               ok7_q;
  logic signed [59:0] prod7_q;

  always_ff @(posedge clk_i) begin
    if (en7) begin
      ok7_q   <= ok6_q;
      prod7_q <= 60'(val6_q) * 60'(z_scale_q);
    end
  end

  // Output stage: floor shift, offset and saturation; a query outside the domain gives zero.
  localparam logic signed [44:0] ElevMax = 45'sd549755813887;
  localparam logic signed [44:0] ElevMin = -45'sd549755813888;

  logic signed [44:0] sum;
  logic signed [39:0] elev_d;
  logic signed [39:0] elev_q;
  logic               indom_q;

  always_comb begin
    sum = 45'(prod7_q >>> 16) + 45'(base_z_q);
    if (!ok7_q) begin
      elev_d = '0;
    end else if (sum > ElevMax) begin
      elev_d = ElevMax[39:0];
    end else if (sum < ElevMin) begin
      elev_d = ElevMin[39:0];
    end else begin
      elev_d = sum[39:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      elev_q  <= elev_d;
      indom_q <= ok7_q;
    end
  end

  assign out_valid_o = ov_q;
  assign elevation_o = elev_q;
  assign in_domain_o = indom_q;

  `TGHI_ASSERT(a_outside_zero, (out_valid_o && !in_domain_o) |-> (elevation_o == 40'sd0), "outside query with nonzero elevation")
  `TGHI_ASSERT(a_stall_only_full, in_stall_o |-> (ov_q && out_stall_i && v1_q && v7_q), "input stalled while pipeline has room")
  `TGHI_ASSERT_ALWAYS(a_bank_one_op, (bank_we & bank_re) == '0, "bank read and written in one cycle")
  `TGHI_ASSERT_ALWAYS(a_one_bank_write, $onehot0(bank_we), "more than one bank written")

endmodule
